FILE: rtl/core/vtp_pkg.sv
// Package for the velocity-to-position joint controller.
// Holds payload and state types, register codes, motion codes and rounding helpers.
// No dependencies.
package vtp_pkg;

    localparam int MAX_JOINTS  = 8;
    localparam int JOINT_LIMIT = (MAX_JOINTS < 8) ? MAX_JOINTS : 8;
    localparam int JW          = $clog2(JOINT_LIMIT);
    localparam int CW          = JW + 1;
    localparam int OFF_DEPTH   = JOINT_LIMIT * JOINT_LIMIT;
    localparam int AW          = 5;
    localparam int DIV_W       = 48;

    localparam logic [2:0] REG_JOINT_COUNT = 3'd0;
    localparam logic [2:0] REG_P_GAIN      = 3'd1;
    localparam logic [2:0] REG_D_GAIN      = 3'd2;
    localparam logic [2:0] REG_SYNC_GAIN   = 3'd3;
    localparam logic [2:0] REG_STOP_THR    = 3'd4;
    localparam logic [2:0] REG_GROUP_MAP   = 3'd5;

    localparam logic [1:0] MS_MOVING   = 2'd0;
    localparam logic [1:0] MS_STOPPING = 2'd1;
    localparam logic [1:0] MS_STOPPED  = 2'd2;

    typedef struct packed {
        logic signed [31:0] measured_position;
        logic signed [31:0] measured_velocity;
        logic               state_valid;
        logic signed [31:0] velocity_command;
        logic               command_present;
        logic               emergency_stop;
        logic [15:0]        period;
        logic               last_joint;
    } t_in;

    typedef struct packed {
        logic [2:0]         joint_number;
        logic signed [31:0] position_command;
        logic               write_enable;
        logic               status;
        logic               last_result;
    } t_out;

    typedef struct packed {
        logic [3:0]  joint_count;
        logic [15:0] proportional_gain;
        logic [15:0] derivative_gain;
        logic [15:0] sync_gain;
        logic [30:0] stop_velocity_threshold;
        logic [23:0] group_map;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] cmd;
        logic               pres;
    } t_samp;

    typedef struct packed {
        logic signed [31:0] prev_vel;
        logic               prev_valid;
        logic [1:0]         ms;
        logic signed [31:0] hold;
        logic               hold_valid;
    } t_jst;

    localparam t_jst JST_RESET = '{32'sd0, 1'b0, MS_STOPPED, 32'sd0, 1'b0};

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic logic signed [63:0] rnd_shr8(input logic signed [63:0] x);
        return (x + 64'sd128) >>> 8;
    endfunction

    function automatic logic signed [63:0] rnd_shr16(input logic signed [63:0] x);
        return (x + 64'sd32768) >>> 16;
    endfunction

endpackage

FILE: rtl/core/velocity_to_position_joint_controller_top.sv
// Top level of the velocity-to-position joint controller: sequencer and datapath.
// Depends on vtp_pkg, vtp_ram (sample, joint state and offset stores) and vtp_regs.
//
// Joint samples are taken one per beat; a loaded sample passes through ST_LOAD, a dropped
// one does not. The beat marked last_joint starts the tick. Per joint of an N-joint tick
// the sequencer scans the sample store twice, reading a pair of rows per step, reads the
// joint state, runs six steps on one shared 42x18 multiplier and emits; a synchronised
// joint adds a bit-serial divide by the number of other joints in its group. Each tick
// that is neither an error nor an e-stop tick first squares the period; an error tick
// emits one error result, an e-stop tick emits each joint's measured position. Results
// leave through an output register, so the next sample is taken while the last result
// still waits.
module velocity_to_position_joint_controller_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  vtp_pkg::t_in           i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output vtp_pkg::t_out          o_out_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [vtp_pkg::AW-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import vtp_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_LOAD  = 5'd1;
    localparam logic [4:0] ST_TICK  = 5'd2;
    localparam logic [4:0] ST_T2    = 5'd3;
    localparam logic [4:0] ST_ES_RD = 5'd4;
    localparam logic [4:0] ST_ES_EM = 5'd5;
    localparam logic [4:0] ST_K1_RD = 5'd6;
    localparam logic [4:0] ST_K1_EV = 5'd7;
    localparam logic [4:0] ST_K2_RD = 5'd8;
    localparam logic [4:0] ST_K2_EV = 5'd9;
    localparam logic [4:0] ST_J_RD  = 5'd10;
    localparam logic [4:0] ST_J_EV  = 5'd11;
    localparam logic [4:0] ST_M2    = 5'd12;
    localparam logic [4:0] ST_M3    = 5'd13;
    localparam logic [4:0] ST_M4    = 5'd14;
    localparam logic [4:0] ST_M5    = 5'd15;
    localparam logic [4:0] ST_M6    = 5'd16;
    localparam logic [4:0] ST_M7    = 5'd17;
    localparam logic [4:0] ST_S1    = 5'd18;
    localparam logic [4:0] ST_DIV   = 5'd19;
    localparam logic [4:0] ST_S2    = 5'd20;
    localparam logic [4:0] ST_EMIT  = 5'd21;

    t_cfg w_cfg;

    // control registers
    logic [4:0]           r_state, n_state;
    logic [CW-1:0]        r_load_cnt, n_load_cnt;
    logic                 r_allv, n_allv;
    logic [JOINT_LIMIT-1:0] r_jst_vld, n_jst_vld;
    logic [OFF_DEPTH-1:0] r_off_vld, n_off_vld;
    logic                 r_out_valid, n_out_valid;

    // payload registers
    t_in                  r_in, n_in;
    t_out                 r_out, n_out;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [JW-1:0]        r_j, n_j;
    logic [JW-1:0]        r_k, n_k;
    logic                 r_same, n_same;
    logic                 r_others, n_others;
    logic                 r_flag, n_flag;
    logic signed [41:0]   r_sum, n_sum;
    logic [2:0]           r_m, n_m;
    logic [1:0]           r_ms, n_ms;
    logic [16:0]          r_t2, n_t2;
    logic signed [59:0]   r_prod, n_prod;
    logic signed [41:0]   r_pe, n_pe;
    logic signed [41:0]   r_de, n_de;
    logic signed [63:0]   r_acc, n_acc;
    logic signed [63:0]   r_next, n_next;
    logic                 r_neg, n_neg;
    logic [DIV_W-1:0]     r_dvd, n_dvd;
    logic [2:0]           r_rem, n_rem;
    logic [5:0]           r_bit, n_bit;

    // memory ports
    logic                 sa_re, sb_re, s_we, j_re, j_we, o_re, o_we;
    logic [JW-1:0]        sa_raddr, sb_raddr, s_waddr, j_raddr, j_waddr;
    logic [2*JW-1:0]      o_raddr, o_waddr;
    t_samp                s_wdata, sa_rdata, sb_rdata;
    t_jst                 j_wdata, j_rdata;
    logic [31:0]          o_wdata, o_rdata;

    logic                 w_out_free;
    logic [CW-1:0]        w_n;
    logic [JW-1:0]        w_jidx;
    t_jst                 w_jst;
    logic signed [31:0]   w_off;
    logic signed [41:0]   w_mul_a;
    logic signed [17:0]   w_mul_b;
    logic signed [59:0]   w_prod;

    vtp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // two copies of the sample store, written together, so row j and row k read at once
    vtp_ram #(.WIDTH($bits(t_samp)), .DEPTH(JOINT_LIMIT)) u_samp_a (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_re(sa_re), .i_raddr(sa_raddr), .o_rdata(sa_rdata)
    );

    vtp_ram #(.WIDTH($bits(t_samp)), .DEPTH(JOINT_LIMIT)) u_samp_b (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_re(sb_re), .i_raddr(sb_raddr), .o_rdata(sb_rdata)
    );

    vtp_ram #(.WIDTH($bits(t_jst)), .DEPTH(JOINT_LIMIT)) u_jst (
        .i_clk(i_clk), .i_we(j_we), .i_waddr(j_waddr), .i_wdata(j_wdata),
        .i_re(j_re), .i_raddr(j_raddr), .o_rdata(j_rdata)
    );

    vtp_ram #(.WIDTH(32), .DEPTH(OFF_DEPTH)) u_off (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_waddr), .i_wdata(o_wdata),
        .i_re(o_re), .i_raddr(o_raddr), .o_rdata(o_rdata)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        logic [3:0] c;
        c = (w_cfg.joint_count == 4'd0) ? 4'd1 : w_cfg.joint_count;
        if (c > 4'(JOINT_LIMIT)) begin
            c = 4'(JOINT_LIMIT);
        end
        w_n = CW'(c);
    end

    assign w_jidx = (r_state == ST_LOAD) ? r_load_cnt[JW-1:0] : r_j;
    assign w_jst  = r_jst_vld[w_jidx] ? j_rdata : JST_RESET;
    assign w_off  = r_off_vld[{r_j, r_k}] ? o_rdata : 32'sd0;
    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        logic          j_last, k_last, grp_eq, same_nx, others_nx, valid;
        logic [CW-1:0] cnt;
        logic [1:0]    ms_nx;
        logic [31:0]   mag;
        logic [3:0]    t;
        logic          ge;
        logic signed [63:0] y, z, q;

        n_state = r_state;     n_load_cnt = r_load_cnt; n_allv = r_allv;
        n_jst_vld = r_jst_vld; n_off_vld = r_off_vld;   n_in = r_in;
        n_cnt = r_cnt; n_j = r_j; n_k = r_k; n_same = r_same; n_others = r_others;
        n_flag = r_flag; n_sum = r_sum; n_m = r_m; n_ms = r_ms; n_t2 = r_t2;
        n_prod = r_prod; n_pe = r_pe; n_de = r_de; n_acc = r_acc; n_next = r_next;
        n_neg = r_neg; n_dvd = r_dvd; n_rem = r_rem; n_bit = r_bit;

        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        sa_re = 1'b0; sa_raddr = r_j;
        sb_re = 1'b0; sb_raddr = r_k;
        s_we  = 1'b0; s_waddr  = r_load_cnt[JW-1:0]; s_wdata = '0;
        j_re  = 1'b0; j_raddr  = r_j;
        j_we  = 1'b0; j_waddr  = r_j; j_wdata = w_jst;
        o_re  = 1'b0; o_raddr  = {r_j, r_k};
        o_we  = 1'b0; o_waddr  = {r_j, r_k}; o_wdata = '0;
        w_mul_a = '0; w_mul_b = '0;

        j_last = (CW'(r_j) + CW'(1)) == r_cnt;
        k_last = (CW'(r_k) + CW'(1)) == r_cnt;
        grp_eq = w_cfg.group_map[3*r_k +: 3] == w_cfg.group_map[3*r_j +: 3];
        cnt    = (r_load_cnt < w_n) ? r_load_cnt : w_n;
        valid  = r_in.state_valid;
        same_nx = r_same; others_nx = r_others;
        mag = sa_rdata.vel[31] ? 32'(-sa_rdata.vel) : 32'(sa_rdata.vel);
        t = 4'd0; ge = 1'b0; y = '0; z = '0; q = '0;

        case (w_jst.ms)
            MS_MOVING:   ms_nx = (sa_rdata.cmd == 32'sd0) ? MS_STOPPING : MS_MOVING;
            MS_STOPPING: begin
                if (sa_rdata.cmd != 32'sd0) begin
                    ms_nx = MS_MOVING;
                end else if (mag <= {1'b0, w_cfg.stop_velocity_threshold}) begin
                    ms_nx = MS_STOPPED;
                end else begin
                    ms_nx = MS_STOPPING;
                end
            end
            default:     ms_nx = (sa_rdata.cmd != 32'sd0) ? MS_MOVING : MS_STOPPED;
        endcase

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in_data;
                    if (r_load_cnt < w_n) begin
                        sa_re = 1'b1; sa_raddr = r_load_cnt[JW-1:0];
                        j_re  = 1'b1; j_raddr  = r_load_cnt[JW-1:0];
                        n_state = ST_LOAD;
                    end else if (i_in_data.last_joint) begin
                        n_state = ST_TICK;
                    end
                end
            end
            ST_LOAD: begin
                s_we = 1'b1;
                s_wdata.pos  = r_in.measured_position;
                s_wdata.vel  = valid ? r_in.measured_velocity : sa_rdata.vel;
                s_wdata.cmd  = r_in.velocity_command;
                s_wdata.pres = r_in.command_present;
                j_we = 1'b1; j_waddr = r_load_cnt[JW-1:0];
                if (valid) begin
                    j_wdata.prev_vel = w_jst.prev_valid ? sa_rdata.vel
                                                        : r_in.measured_velocity;
                end
                j_wdata.prev_valid = valid;
                n_jst_vld[r_load_cnt[JW-1:0]] = 1'b1;
                n_allv     = r_allv && valid;
                n_load_cnt = r_load_cnt + CW'(1);
                n_state    = r_in.last_joint ? ST_TICK : ST_IDLE;
            end
            ST_TICK: begin
                if (!r_allv) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out = '{3'd0, 32'sd0, 1'b0, 1'b1, 1'b1};
                        n_load_cnt = '0; n_allv = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_cnt = cnt; n_load_cnt = '0; n_allv = 1'b1; n_j = '0;
                    if (r_in.emergency_stop) begin
                        n_state = ST_ES_RD;
                    end else begin
                        w_mul_a = 42'(signed'({1'b0, r_in.period}));
                        w_mul_b = signed'({2'b0, r_in.period});
                        n_prod  = w_prod;
                        n_state = ST_T2;
                    end
                end
            end
            ST_T2: begin
                y = rnd_shr16(64'(r_prod));
                n_t2 = y[16:0];
                n_k = '0; n_same = 1'b1; n_others = 1'b0;
                n_state = ST_K1_RD;
            end
            ST_ES_RD: begin
                sa_re = 1'b1; j_re = 1'b1;
                n_state = ST_ES_EM;
            end
            ST_ES_EM: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{3'(r_j), sa_rdata.pos, 1'b1, 1'b0, j_last};
                    j_we = 1'b1;
                    j_wdata.hold = sa_rdata.pos; j_wdata.hold_valid = 1'b1;
                    n_jst_vld[r_j] = 1'b1;
                    n_j = r_j + JW'(1);
                    n_state = j_last ? ST_IDLE : ST_ES_RD;
                end
            end
            ST_K1_RD: begin
                sa_re = 1'b1; sb_re = 1'b1;
                n_state = ST_K1_EV;
            end
            ST_K1_EV: begin
                if (grp_eq) begin
                    if (r_k != r_j) begin
                        others_nx = 1'b1;
                    end
                    if (!(sa_rdata.pres && sb_rdata.pres && sa_rdata.cmd == sb_rdata.cmd)) begin
                        same_nx = 1'b0;
                    end
                end
                n_same = same_nx; n_others = others_nx;
                if (k_last) begin
                    n_flag = same_nx && others_nx;
                    n_k = '0; n_sum = '0; n_m = '0;
                    n_state = ST_K2_RD;
                end else begin
                    n_k = r_k + JW'(1);
                    n_state = ST_K1_RD;
                end
            end
            ST_K2_RD: begin
                sa_re = 1'b1; sb_re = 1'b1; o_re = 1'b1;
                n_state = ST_K2_EV;
            end
            ST_K2_EV: begin
                if (r_k != r_j && grp_eq) begin
                    if (r_flag) begin
                        n_sum = r_sum + 42'(sb_rdata.pos) - 42'(sa_rdata.pos) - 42'(w_off);
                        n_m   = r_m + 3'd1;
                    end else begin
                        o_we = 1'b1;
                        o_wdata = sat32(64'(sb_rdata.pos) - 64'(sa_rdata.pos));
                        n_off_vld[{r_j, r_k}] = 1'b1;
                    end
                end
                if (k_last) begin
                    n_state = ST_J_RD;
                end else begin
                    n_k = r_k + JW'(1);
                    n_state = ST_K2_RD;
                end
            end
            ST_J_RD: begin
                sa_re = 1'b1; j_re = 1'b1;
                n_state = ST_J_EV;
            end
            ST_J_EV: begin
                if (!sa_rdata.pres || ms_nx == MS_STOPPED) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        if (!sa_rdata.pres) begin
                            n_out = '{3'(r_j), 32'sd0, 1'b0, 1'b0, j_last};
                        end else begin
                            n_out = '{3'(r_j), w_jst.hold_valid ? w_jst.hold : 32'sd0,
                                      w_jst.hold_valid, 1'b0, j_last};
                            j_we = 1'b1; j_wdata.ms = MS_STOPPED;
                            n_jst_vld[r_j] = 1'b1;
                        end
                        n_j = r_j + JW'(1);
                        n_k = '0; n_same = 1'b1; n_others = 1'b0;
                        n_state = j_last ? ST_IDLE : ST_K1_RD;
                    end
                end else begin
                    n_ms = ms_nx;
                    w_mul_a = 42'(sa_rdata.cmd) - 42'(sa_rdata.vel);
                    w_mul_b = signed'({2'b0, w_cfg.proportional_gain});
                    n_prod  = w_prod;
                    n_state = ST_M2;
                end
            end
            ST_M2: begin
                y = rnd_shr8(64'(r_prod));
                n_pe = y[41:0];
                w_mul_a = 42'(sa_rdata.vel) - 42'(w_jst.prev_vel);
                w_mul_b = signed'({2'b0, w_cfg.derivative_gain});
                n_prod  = w_prod;
                n_state = ST_M3;
            end
            ST_M3: begin
                y = rnd_shr8(64'(r_prod));
                n_de = y[41:0];
                w_mul_a = 42'(sa_rdata.cmd);
                w_mul_b = signed'({2'b0, r_in.period});
                n_prod  = w_prod;
                n_state = ST_M4;
            end
            ST_M4: begin
                n_acc = (64'(sa_rdata.pos) <<< 16) + 64'(r_prod);
                w_mul_a = r_pe;
                w_mul_b = signed'({2'b0, r_in.period});
                n_prod  = w_prod;
                n_state = ST_M5;
            end
            ST_M5: begin
                n_acc = r_acc + 64'(r_prod);
                w_mul_a = r_de;
                w_mul_b = signed'({1'b0, r_t2});
                n_prod  = w_prod;
                n_state = ST_M6;
            end
            ST_M6: begin
                n_acc = r_acc - 64'(r_prod);
                n_state = ST_M7;
            end
            ST_M7: begin
                n_next = rnd_shr16(r_acc);
                if (r_flag) begin
                    w_mul_a = r_sum;
                    w_mul_b = signed'({2'b0, w_cfg.sync_gain});
                    n_prod  = w_prod;
                    n_state = ST_S1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_S1: begin
                // floor((x + 128m) / 256m) = floor(floor((x + 128m) / 256) / m)
                y = 64'(r_prod) + 64'(signed'({1'b0, r_m, 7'd0}));
                z = y >>> 8;
                n_neg = z[63];
                q = z[63] ? -z : z;
                n_dvd = q[DIV_W-1:0];
                n_rem = '0; n_bit = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                t  = {r_rem, r_dvd[DIV_W-1]};
                ge = t >= {1'b0, r_m};
                n_rem = ge ? 3'(t - {1'b0, r_m}) : t[2:0];
                n_dvd = {r_dvd[DIV_W-2:0], ge};
                n_bit = r_bit + 6'd1;
                if (r_bit == 6'(DIV_W - 1)) begin
                    n_state = ST_S2;
                end
            end
            ST_S2: begin
                q = 64'({1'b0, r_dvd});
                if (r_neg) begin
                    q = -q - ((r_rem != 3'd0) ? 64'sd1 : 64'sd0);
                end
                n_next = r_next + q;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{3'(r_j), sat32(r_next), 1'b1, 1'b0, j_last};
                    j_we = 1'b1;
                    j_wdata.ms = r_ms; j_wdata.hold = sa_rdata.pos; j_wdata.hold_valid = 1'b1;
                    n_jst_vld[r_j] = 1'b1;
                    n_j = r_j + JW'(1);
                    n_k = '0; n_same = 1'b1; n_others = 1'b0;
                    n_state = j_last ? ST_IDLE : ST_K1_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_load_cnt  <= '0;
            r_allv      <= 1'b1;
            r_jst_vld   <= '0;
            r_off_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_cnt  <= n_load_cnt;
            r_allv      <= n_allv;
            r_jst_vld   <= n_jst_vld;
            r_off_vld   <= n_off_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;     r_out <= n_out;   r_cnt <= n_cnt;   r_j <= n_j;
        r_k <= n_k;       r_same <= n_same; r_others <= n_others;
        r_flag <= n_flag; r_sum <= n_sum;   r_m <= n_m;       r_ms <= n_ms;
        r_t2 <= n_t2;     r_prod <= n_prod; r_pe <= n_pe;     r_de <= n_de;
        r_acc <= n_acc;   r_next <= n_next; r_neg <= n_neg;   r_dvd <= n_dvd;
        r_rem <= n_rem;   r_bit <= n_bit;
    end

endmodule

FILE: rtl/core/vtp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module vtp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/vtp_regs.sv
// APB-style configuration registers of the joint controller.
// Depends on vtp_pkg for the register codes and the t_cfg bundle.
module vtp_regs (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [vtp_pkg::AW-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output vtp_pkg::t_cfg          o_cfg
);
    import vtp_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;

    assign w_idx  = paddr[AW-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.joint_count             <= 4'd1;
            r_cfg.proportional_gain       <= 16'd256;
            r_cfg.derivative_gain         <= 16'd256;
            r_cfg.sync_gain               <= 16'd256;
            r_cfg.stop_velocity_threshold <= 31'd655;
            r_cfg.group_map               <= 24'd16434824;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_JOINT_COUNT: r_cfg.joint_count             <= pwdata[3:0];
                REG_P_GAIN:      r_cfg.proportional_gain       <= pwdata[15:0];
                REG_D_GAIN:      r_cfg.derivative_gain         <= pwdata[15:0];
                REG_SYNC_GAIN:   r_cfg.sync_gain               <= pwdata[15:0];
                REG_STOP_THR:    r_cfg.stop_velocity_threshold <= pwdata[30:0];
                REG_GROUP_MAP:   r_cfg.group_map               <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_JOINT_COUNT: prdata = {28'd0, r_cfg.joint_count};
            REG_P_GAIN:      prdata = {16'd0, r_cfg.proportional_gain};
            REG_D_GAIN:      prdata = {16'd0, r_cfg.derivative_gain};
            REG_SYNC_GAIN:   prdata = {16'd0, r_cfg.sync_gain};
            REG_STOP_THR:    prdata = {1'b0, r_cfg.stop_velocity_threshold};
            REG_GROUP_MAP:   prdata = {8'd0, r_cfg.group_map};
            default:         prdata = 32'd0;
        endcase
    end

endmodule
